// ===== sv/lcsw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcsw_pkg: shared constants and types
// Cube size, segment store depth, direction codes and the command and status
// bundles between the snake walker controller and datapath.
// ----------------------------------------------------------------------------
package lcsw_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int CUBE_MAX     = 4;
  localparam int NUM_DIRS     = 6;

  localparam int COORD_W   = 3;
  localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
  localparam int LEN_W     = 6;
  localparam int DIR_W     = 3;
  localparam int TRY_W     = 3;

  localparam logic [DIR_W-1:0] DIR_X_NEG = 3'd0;
  localparam logic [DIR_W-1:0] DIR_X_POS = 3'd1;
  localparam logic [DIR_W-1:0] DIR_Y_NEG = 3'd2;
  localparam logic [DIR_W-1:0] DIR_Y_POS = 3'd3;
  localparam logic [DIR_W-1:0] DIR_Z_NEG = 3'd4;
  localparam logic [DIR_W-1:0] DIR_Z_POS = 3'd5;

  localparam logic [TRY_W-1:0] LAST_TRY = TRY_W'(NUM_DIRS);

  typedef struct packed {
    logic start;
    logic probe;
    logic next_try;
    logic found;
    logic fail;
    logic emit;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic blocked;
    logic last_try;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/lcsw_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcsw_ctrl: round sequencer
// Accepts a round, walks the candidate directions, emits the segments and
// commits the move or the restart.
// ----------------------------------------------------------------------------
module lcsw_ctrl
  import lcsw_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_APPLY = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (!status.blocked) begin
          cmd.found  = 1'b1;
          state_next = S_EMIT;
        end else if (status.last_try) begin
          cmd.fail   = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.next_try = 1'b1;
          state_next   = S_PROBE;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_last) begin
            state_next = S_APPLY;
          end
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/lcsw_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcsw_dp: snake datapath
// Segment store, length register, candidate head and collision check, and
// the output register for segment transfers.
// ----------------------------------------------------------------------------
module lcsw_dp
  import lcsw_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cfg_wr_en,
  input  wire  [LEN_W-1:0]       cfg_wr_data,
  input  wire  [DIR_W-1:0]       random_dir,
  input  wire  cmd_t             cmd,
  output status_t                status,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [SEG_IDX_W-1:0]   seg_index,
  output logic [COORD_W-1:0]     seg_x,
  output logic [COORD_W-1:0]     seg_y,
  output logic [COORD_W-1:0]     seg_z,
  output logic                   last_seg,
  output logic                   restarted
);

  localparam int CW1 = COORD_W + 1;

  logic [LEN_W-1:0]     snake_length;
  logic [SEG_IDX_W-1:0] n_m1;
  logic [SEG_IDX_W-1:0] n_m1_next;
  logic [DIR_W-1:0]     pref;
  logic [TRY_W-1:0]     try_cnt;
  logic [SEG_IDX_W-1:0] idx;
  logic                 fail;

  logic [COORD_W-1:0] sx [MAX_SEGMENTS];
  logic [COORD_W-1:0] sy [MAX_SEGMENTS];
  logic [COORD_W-1:0] sz [MAX_SEGMENTS];

  logic [COORD_W-1:0]      cand_x;
  logic [COORD_W-1:0]      cand_y;
  logic [COORD_W-1:0]      cand_z;
  logic                    cand_ok;
  logic [MAX_SEGMENTS-1:0] hits;

  logic [DIR_W-1:0]        dir;
  logic [CW1-1:0]          cx;
  logic [CW1-1:0]          cy;
  logic [CW1-1:0]          cz;
  logic                    in_cube;
  logic [MAX_SEGMENTS-1:0] hits_next;
  logic [MAX_SEGMENTS-1:0] mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      snake_length <= LEN_W'(4);
    end else if (cfg_wr_en) begin
      snake_length <= cfg_wr_data;
    end
  end

  always_comb begin
    priority if (snake_length == '0) begin
      n_m1_next = '0;
    end else if (snake_length > LEN_W'(MAX_SEGMENTS)) begin
      n_m1_next = SEG_IDX_W'(MAX_SEGMENTS - 1);
    end else begin
      n_m1_next = SEG_IDX_W'(snake_length - LEN_W'(1));
    end
  end

  // candidate head for the current try
  always_comb begin
    dir = (try_cnt == '0) ? pref : DIR_W'(try_cnt - TRY_W'(1));
    cx  = {1'b0, sx[0]};
    cy  = {1'b0, sy[0]};
    cz  = {1'b0, sz[0]};
    unique case (dir)
      DIR_X_NEG: cx = cx - CW1'(1);
      DIR_X_POS: cx = cx + CW1'(1);
      DIR_Y_NEG: cy = cy - CW1'(1);
      DIR_Y_POS: cy = cy + CW1'(1);
      DIR_Z_NEG: cz = cz - CW1'(1);
      DIR_Z_POS: cz = cz + CW1'(1);
      default: begin
      end
    endcase
    in_cube = (cx <= CW1'(CUBE_MAX)) && (cy <= CW1'(CUBE_MAX)) &&
              (cz <= CW1'(CUBE_MAX));
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      hits_next[i] = (sx[i] == cx[COORD_W-1:0]) && (sy[i] == cy[COORD_W-1:0]) &&
                     (sz[i] == cz[COORD_W-1:0]);
      mask[i]      = (SEG_IDX_W'(i) < n_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pref <= random_dir;
      n_m1 <= n_m1_next;
    end
    if (cmd.probe) begin
      cand_x  <= cx[COORD_W-1:0];
      cand_y  <= cy[COORD_W-1:0];
      cand_z  <= cz[COORD_W-1:0];
      cand_ok <= in_cube;
      hits    <= hits_next;
    end
    if (cmd.found) begin
      fail <= 1'b0;
    end else if (cmd.fail) begin
      fail <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      try_cnt <= '0;
      idx     <= '0;
    end else begin
      if (cmd.start) begin
        try_cnt <= '0;
      end else if (cmd.next_try) begin
        try_cnt <= try_cnt + TRY_W'(1);
      end
      if (cmd.start) begin
        idx <= '0;
      end else if (cmd.emit) begin
        idx <= idx + SEG_IDX_W'(1);
      end
    end
  end

  // segment store: shift toward the tail on a move, clear on a restart
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_SEGMENTS; i++) begin
        sx[i] <= '0;
        sy[i] <= '0;
        sz[i] <= '0;
      end
    end else if (cmd.apply) begin
      if (fail) begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
          if (SEG_IDX_W'(i) <= n_m1) begin
            sx[i] <= '0;
            sy[i] <= '0;
            sz[i] <= '0;
          end
        end
      end else begin
        for (int i = 1; i < MAX_SEGMENTS; i++) begin
          if (SEG_IDX_W'(i) <= n_m1) begin
            sx[i] <= sx[i-1];
            sy[i] <= sy[i-1];
            sz[i] <= sz[i-1];
          end
        end
        sx[0] <= cand_x;
        sy[0] <= cand_y;
        sz[0] <= cand_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      seg_index <= idx;
      seg_x     <= sx[idx];
      seg_y     <= sy[idx];
      seg_z     <= sz[idx];
      last_seg  <= (idx == n_m1);
      restarted <= (idx == n_m1) && fail;
    end
  end

  assign status.blocked   = !cand_ok || ((hits & mask) != '0);
  assign status.last_try  = (try_cnt == LAST_TRY);
  assign status.emit_last = (idx == n_m1);
  assign status.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

// ===== sv/led_cube_snake_walker.sv =====
`default_nettype none
// Sequence: a round is accepted, each tried direction is probed and then
// checked (one to seven tries), the segments leave through the per-segment
// output register, one per cycle while out_ready is high, and then the move
// or the restart is committed.
// Reset: synchronous, active high; all segments at the origin, length 4.
// ----------------------------------------------------------------------------
// led_cube_snake_walker: snake walker for a 5x5x5 LED cube
// Emits each segment of the snake, head first, then moves it one step or
// returns it to the origin.
// ----------------------------------------------------------------------------
module led_cube_snake_walker
  import lcsw_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_wr_en,
  input  wire  [LEN_W-1:0]     cfg_wr_data,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [DIR_W-1:0]     random_dir,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [SEG_IDX_W-1:0] seg_index,
  output logic [COORD_W-1:0]   seg_x,
  output logic [COORD_W-1:0]   seg_y,
  output logic [COORD_W-1:0]   seg_z,
  output logic                 last_seg,
  output logic                 restarted
);

  cmd_t    cmd;
  status_t status;

  lcsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lcsw_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .random_dir  (random_dir),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seg_index   (seg_index),
    .seg_x       (seg_x),
    .seg_y       (seg_y),
    .seg_z       (seg_z),
    .last_seg    (last_seg),
    .restarted   (restarted)
  );

endmodule
`default_nettype wire
